// ===== hdl/dsc_pkg.sv =====
package dsc_pkg;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_ACTIVITY    = 3'd1,
    CMD_STATUS      = 3'd2,
    CMD_HOST_STATE  = 3'd3,
    CMD_LED_STATUS  = 3'd4,
    CMD_HOST_TIMER  = 3'd5
  } dsc_cmd_t;

  typedef enum logic [1:0] {
    ST_ACTIVE = 2'd0,
    ST_IDLE   = 2'd1,
    ST_SLEEP  = 2'd2
  } disp_state_t;

  localparam logic [1:0] HOST_READY    = 2'd0;
  localparam logic [1:0] HOST_IDLE     = 2'd1;
  localparam logic [1:0] HOST_PRINTING = 2'd2;

  localparam logic [1:0] MODE_TIMEOUT   = 2'd0;
  localparam logic [1:0] MODE_HOST_SYNC = 2'd1;
  localparam logic [1:0] MODE_LED_SYNC  = 2'd2;

  localparam logic [4:0] LEVEL_ON  = 5'd16;
  localparam logic [4:0] LEVEL_OFF = 5'd0;

  // register indexes on the configuration port
  localparam logic [2:0] REG_SLEEP_MODE   = 3'd0;
  localparam logic [2:0] REG_AUTO_ENABLE  = 3'd1;
  localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_SLEEP_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_HOST_DELAY   = 3'd4;

  // reset values of the registers
  localparam logic [1:0] RST_SLEEP_MODE    = MODE_HOST_SYNC;
  localparam logic       RST_AUTO_ENABLE   = 1'b1;
  localparam int         RST_IDLE_SEC      = 30;
  localparam int         RST_SLEEP_SEC     = 60;
  localparam int         RST_HOST_DELAY_SEC = 30;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] host_state;
    logic       leds_on;
    logic       busy_printing;
    logic       busy_homing;
    logic       busy_probing;
    logic       busy_leveling;
    logic       busy_heating_nozzle;
    logic       busy_heating_bed;
    logic       host_not_ready;
    logic       host_disconnected;
  } in_word_t;

  typedef struct packed {
    logic [1:0] display_state;
    logic [4:0] backlight_level;
    logic       backlight_write;
    logic       refresh_request;
    logic [1:0] host_state_now;
    logic       leds_active_now;
  } out_word_t;

  typedef struct packed {
    logic [1:0] sleep_mode;
    logic       auto_sleep_enable;
  } cfg_ctrl_t;

endpackage

// ===== hdl/dsc_cfg.sv =====
module dsc_cfg
  import dsc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 1000,
  parameter int THR_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output cfg_ctrl_t        ctrl,
  output logic [THR_W-1:0] idle_thr,
  output logic [THR_W-1:0] sleep_thr,
  output logic [THR_W-1:0] host_thr
);

  cfg_ctrl_t        ctrl_r;
  logic [THR_W-1:0] idle_thr_r, sleep_thr_r, host_thr_r;
  logic [THR_W-1:0] thr_nxt;
  logic             wr;

  // seconds are kept as tick thresholds
  assign thr_nxt   = THR_W'(cfg_data) * THR_W'(TICKS_PER_SECOND);
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.sleep_mode        <= RST_SLEEP_MODE;
      ctrl_r.auto_sleep_enable <= RST_AUTO_ENABLE;
      idle_thr_r  <= THR_W'(RST_IDLE_SEC * TICKS_PER_SECOND);
      sleep_thr_r <= THR_W'(RST_SLEEP_SEC * TICKS_PER_SECOND);
      host_thr_r  <= THR_W'(RST_HOST_DELAY_SEC * TICKS_PER_SECOND);
    end else if (wr) begin
      case (cfg_index)
        REG_SLEEP_MODE:    ctrl_r.sleep_mode <= cfg_data[1:0];
        REG_AUTO_ENABLE:   ctrl_r.auto_sleep_enable <= cfg_data[0];
        REG_IDLE_TIMEOUT:  idle_thr_r <= thr_nxt;
        REG_SLEEP_TIMEOUT: sleep_thr_r <= thr_nxt;
        REG_HOST_DELAY:    host_thr_r <= thr_nxt;
        default: ;
      endcase
    end
  end

  assign ctrl      = ctrl_r;
  assign idle_thr  = idle_thr_r;
  assign sleep_thr = sleep_thr_r;
  assign host_thr  = host_thr_r;

endmodule

// ===== hdl/dsc_step.sv =====
module dsc_step
  import dsc_pkg::*;
#(
  parameter int COUNTER_BITS = 26,
  parameter int THR_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  in_word_t         word,
  input  cfg_ctrl_t        ctrl,
  input  logic [THR_W-1:0] idle_thr,
  input  logic [THR_W-1:0] sleep_thr,
  input  logic [THR_W-1:0] host_thr,
  output out_word_t        result
);

  localparam int CMP_W = (COUNTER_BITS > THR_W) ? COUNTER_BITS : THR_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  disp_state_t             st_r, st_nxt;
  logic [COUNTER_BITS-1:0] act_r, act_nxt;
  logic [COUNTER_BITS-1:0] hid_r, hid_nxt;
  logic [1:0]              hs_r, hs_nxt;
  logic                    leds_r, leds_nxt;

  logic       busy;
  logic [4:0] lvl;
  logic       wr, rf, want;
  logic [1:0] ns, old_hs;

  assign busy = word.busy_printing | word.busy_homing | word.busy_probing |
                word.busy_leveling | word.busy_heating_nozzle | word.busy_heating_bed;

  always_comb begin
    st_nxt   = st_r;
    act_nxt  = act_r;
    hid_nxt  = hid_r;
    hs_nxt   = hs_r;
    leds_nxt = leds_r;
    lvl      = LEVEL_OFF;
    wr       = 1'b0;
    rf       = 1'b0;
    want     = 1'b0;
    ns       = (word.host_state > HOST_PRINTING) ? HOST_READY : word.host_state;
    old_hs   = hs_r;

    case (word.command)
      CMD_TICK: begin
        act_nxt = (act_r == CNT_MAX) ? act_r : act_r + 1'b1;
        hid_nxt = (hid_r == CNT_MAX) ? hid_r : hid_r + 1'b1;
        if (!ctrl.auto_sleep_enable) begin
          if (st_r == ST_SLEEP) begin
            lvl = LEVEL_ON; wr = 1'b1; rf = 1'b1;
            st_nxt = ST_ACTIVE; act_nxt = '0;
          end
        end else if (busy) begin
          if (st_r != ST_ACTIVE) begin
            if (st_r == ST_SLEEP) begin
              lvl = LEVEL_ON; wr = 1'b1; rf = 1'b1;
            end
            st_nxt  = ST_ACTIVE;
            act_nxt = '0;
          end
        end else begin
          case (ctrl.sleep_mode)
            MODE_TIMEOUT: begin
              if (st_r == ST_ACTIVE) begin
                if (CMP_W'(act_nxt) >= CMP_W'(idle_thr)) st_nxt = ST_IDLE;
              end else if (st_r == ST_IDLE) begin
                want = CMP_W'(act_nxt) >= CMP_W'(sleep_thr);
              end
            end
            MODE_HOST_SYNC: begin
              want = !word.host_not_ready && !word.host_disconnected &&
                     (hs_r == HOST_IDLE) && (CMP_W'(hid_nxt) >= CMP_W'(host_thr));
            end
            MODE_LED_SYNC: want = !leds_r;
            default: ;
          endcase
          if (want && st_r != ST_SLEEP) begin
            lvl = LEVEL_OFF; wr = 1'b1; st_nxt = ST_SLEEP;
          end
        end
      end
      CMD_ACTIVITY: begin
        act_nxt = '0;
        if (st_r == ST_SLEEP) begin
          lvl = LEVEL_ON; wr = 1'b1; rf = 1'b1;
        end
        if (st_r != ST_ACTIVE) st_nxt = ST_ACTIVE;
      end
      CMD_STATUS: begin
        if (st_r == ST_SLEEP) begin
          lvl = LEVEL_ON; wr = 1'b1; rf = 1'b1;
          st_nxt = ST_ACTIVE; act_nxt = '0;
        end else if (st_r == ST_IDLE) begin
          st_nxt = ST_ACTIVE; act_nxt = '0;
        end
      end
      CMD_HOST_STATE: begin
        if (ns != old_hs) begin
          hs_nxt = ns;
          if (ns == HOST_IDLE) hid_nxt = '0;
          // leaving host idle: wake and restart activity time
          if (old_hs == HOST_IDLE) begin
            act_nxt = '0;
            if (st_r == ST_SLEEP) begin
              lvl = LEVEL_ON; wr = 1'b1; rf = 1'b1;
            end
            st_nxt = ST_ACTIVE;
          end
        end
      end
      CMD_LED_STATUS: begin
        if (word.leds_on != leds_r) begin
          leds_nxt = word.leds_on;
          if (!word.leds_on && ctrl.sleep_mode == MODE_LED_SYNC) begin
            if (st_r != ST_SLEEP && !busy) begin
              lvl = LEVEL_OFF; wr = 1'b1; st_nxt = ST_SLEEP;
            end
          end else if (word.leds_on && st_r == ST_SLEEP) begin
            lvl = LEVEL_ON; wr = 1'b1; rf = 1'b1;
            st_nxt = ST_ACTIVE; act_nxt = '0;
          end
        end
      end
      CMD_HOST_TIMER: begin
        hid_nxt = '0;
        if (st_r == ST_SLEEP) begin
          lvl = LEVEL_ON; wr = 1'b1; rf = 1'b1;
          st_nxt = ST_ACTIVE; act_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_ACTIVE;
      act_r  <= '0;
      hid_r  <= '0;
      hs_r   <= HOST_READY;
      leds_r <= 1'b1;
    end else if (fire) begin
      st_r   <= st_nxt;
      act_r  <= act_nxt;
      hid_r  <= hid_nxt;
      hs_r   <= hs_nxt;
      leds_r <= leds_nxt;
    end
  end

  assign result.display_state   = st_nxt;
  assign result.backlight_level = wr ? lvl : LEVEL_OFF;
  assign result.backlight_write = wr;
  assign result.refresh_request = rf;
  assign result.host_state_now  = hs_nxt;
  assign result.leds_active_now = leds_nxt;

endmodule

// ===== hdl/display_sleep_controller.sv =====
// Display sleep controller: tracks an active / idle / sleeping display from a stream of
// 1 ms ticks and events, and tells the host when to drive the backlight and when to
// refresh the screen. One word is accepted every clock unless out_ready holds the result
// register full, and each word returns exactly one result word through the input register,
// then the result register. Timeouts written in seconds are stored as tick thresholds,
// so no division is needed.
module display_sleep_controller
  import dsc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 1000,
  parameter int COUNTER_BITS     = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // threshold width: 16-bit seconds times ticks per second
  localparam int THR_W = 16 + $clog2(TICKS_PER_SECOND + 1);

  cfg_ctrl_t        ctrl;
  logic [THR_W-1:0] idle_thr, sleep_thr, host_thr;

  // input register stage
  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      s1_adv;

  // result register stage
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t step_result;

  // stage 1 moves on whenever the result register is free or being drained
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_word;
    end
  end

  dsc_cfg #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .THR_W            (THR_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .idle_thr  (idle_thr),
    .sleep_thr (sleep_thr),
    .host_thr  (host_thr)
  );

  // state commits in the same cycle the word lands in the result register
  dsc_step #(
    .COUNTER_BITS (COUNTER_BITS),
    .THR_W        (THR_W)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_valid_r && s1_adv),
    .word      (s1_word_r),
    .ctrl      (ctrl),
    .idle_thr  (idle_thr),
    .sleep_thr (sleep_thr),
    .host_thr  (host_thr),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_word_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // no backlight change reports level zero
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.backlight_write |-> out_word.backlight_level == LEVEL_OFF)
    else $error("backlight level set without a write");

  // a refresh only comes with a wake to full backlight
  a_refresh_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.refresh_request |->
      out_word.backlight_write && out_word.backlight_level == LEVEL_ON &&
      out_word.display_state == ST_ACTIVE)
    else $error("refresh without wake");

  // a backlight write to zero means the display went to sleep
  a_sleep_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.backlight_write && out_word.backlight_level == LEVEL_OFF |->
      out_word.display_state == ST_SLEEP)
    else $error("backlight off while not sleeping");

  // a word held in stage 1 by a full result register stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_word_r))
    else $error("stage 1 word lost under stall");

endmodule

// ===== tb/dsc_result_checker.sv =====
`timescale 1ns / 100ps

module dsc_result_checker
  import dsc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 1000,
  parameter int COUNTER_BITS     = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          status_backlog,
  output int          status_checked,
  output int          wake_count,
  output int          sleep_count
);

  typedef logic [COUNTER_BITS-1:0] ms_count_t;

  // shadow registers
  logic [1:0]  mode;
  logic        auto_en;
  logic [15:0] idle_sec;
  logic [15:0] sleep_sec;
  logic [15:0] delay_sec;

  // shadow display state
  disp_state_t dstate;
  ms_count_t   act_ms;
  ms_count_t   hidle_ms;
  logic [1:0]  host_st;
  logic        leds;

  // backlight effects of the word being predicted
  logic [4:0]  bl_level;
  logic        bl_write;
  logic        refresh;

  out_word_t   status_expected[$];
  int          fails;
  int          checked;
  int          wakes;
  int          sleeps;

  initial begin
    fails   = 0;
    checked = 0;
    wakes   = 0;
    sleeps  = 0;
  end

  function automatic ms_count_t count_ms(input ms_count_t c);
    return (&c) ? c : c + 1'b1;
  endfunction

  task automatic wake_up();
    if (dstate == ST_SLEEP) begin
      bl_level = LEVEL_ON;
      bl_write = 1'b1;
      refresh  = 1'b1;
      dstate   = ST_ACTIVE;
      act_ms   = '0;
    end
  endtask

  task automatic fall_asleep(input logic busy);
    if (dstate != ST_SLEEP && !busy) begin
      bl_level = LEVEL_OFF;
      bl_write = 1'b1;
      dstate   = ST_SLEEP;
    end
  endtask

  task automatic note_activity();
    act_ms = '0;
    if (dstate == ST_SLEEP) wake_up();
    else if (dstate == ST_IDLE) dstate = ST_ACTIVE;
  endtask

  task automatic run_tick(input in_word_t w, input logic busy);
    logic            want;
    longint unsigned secs;
    want     = 1'b0;
    act_ms   = count_ms(act_ms);
    hidle_ms = count_ms(hidle_ms);
    if (!auto_en) begin
      wake_up();
    end else if (busy) begin
      // busy printer pins the display active
      if (dstate != ST_ACTIVE) begin
        wake_up();
        dstate = ST_ACTIVE;
        act_ms = '0;
      end
    end else begin
      case (mode)
        MODE_TIMEOUT: begin
          secs = 64'(act_ms) / 64'(TICKS_PER_SECOND);
          if (dstate == ST_ACTIVE) begin
            if (secs >= idle_sec) dstate = ST_IDLE;
          end else if (dstate == ST_IDLE) begin
            want = (secs >= sleep_sec);
          end
        end
        MODE_HOST_SYNC: begin
          secs = 64'(hidle_ms) / 64'(TICKS_PER_SECOND);
          want = !w.host_not_ready && !w.host_disconnected && host_st == HOST_IDLE &&
                 secs >= delay_sec;
        end
        MODE_LED_SYNC: want = !leds;
        default: want = 1'b0;
      endcase
      if (want) fall_asleep(busy);
    end
  endtask

  task automatic advance_display(input in_word_t w, output out_word_t r);
    logic       busy;
    logic [1:0] next_host;
    logic [1:0] prev_host;
    busy = w.busy_printing | w.busy_homing | w.busy_probing | w.busy_leveling |
           w.busy_heating_nozzle | w.busy_heating_bed;
    bl_level = LEVEL_OFF;
    bl_write = 1'b0;
    refresh  = 1'b0;
    case (w.command)
      CMD_TICK:     run_tick(w, busy);
      CMD_ACTIVITY: note_activity();
      CMD_STATUS: begin
        if (dstate == ST_SLEEP) wake_up();
        else if (dstate == ST_IDLE) note_activity();
      end
      CMD_HOST_STATE: begin
        next_host = (w.host_state > HOST_PRINTING) ? HOST_READY : w.host_state;
        prev_host = host_st;
        if (next_host != prev_host) begin
          host_st = next_host;
          if (next_host == HOST_IDLE) hidle_ms = '0;
          if (prev_host == HOST_IDLE) begin
            wake_up();
            note_activity();
          end
        end
      end
      CMD_LED_STATUS: begin
        if (w.leds_on != leds) begin
          leds = w.leds_on;
          if (!leds && mode == MODE_LED_SYNC) fall_asleep(busy);
          else if (leds) wake_up();
        end
      end
      CMD_HOST_TIMER: begin
        hidle_ms = '0;
        wake_up();
      end
      default: ;
    endcase
    r.display_state   = dstate;
    r.backlight_level = bl_write ? bl_level : LEVEL_OFF;
    r.backlight_write = bl_write;
    r.refresh_request = refresh;
    r.host_state_now  = host_st;
    r.leds_active_now = leds;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0d ns: %s expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want_w;
    if (!rst_n) begin
      mode      = RST_SLEEP_MODE;
      auto_en   = RST_AUTO_ENABLE;
      idle_sec  = 16'(RST_IDLE_SEC);
      sleep_sec = 16'(RST_SLEEP_SEC);
      delay_sec = 16'(RST_HOST_DELAY_SEC);
      dstate    = ST_ACTIVE;
      act_ms    = '0;
      hidle_ms  = '0;
      host_st   = HOST_READY;
      leds      = 1'b1;
      status_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLEEP_MODE:    mode      = cfg_data[1:0];
          REG_AUTO_ENABLE:   auto_en   = cfg_data[0];
          REG_IDLE_TIMEOUT:  idle_sec  = cfg_data;
          REG_SLEEP_TIMEOUT: sleep_sec = cfg_data;
          REG_HOST_DELAY:    delay_sec = cfg_data;
          default: ;
        endcase
      end
      // pop before push so an early result cannot match its own word
      if (out_valid && out_ready) begin
        if (status_expected.size() == 0) begin
          $display("%0d ns: result %h arrived with nothing expected", $time, out_word);
          fails++;
        end else begin
          want_w = status_expected.pop_front();
          check_field("display_state", want_w.display_state, out_word.display_state);
          check_field("backlight_level", want_w.backlight_level, out_word.backlight_level);
          check_field("backlight_write", want_w.backlight_write, out_word.backlight_write);
          check_field("refresh_request", want_w.refresh_request, out_word.refresh_request);
          check_field("host_state_now", want_w.host_state_now, out_word.host_state_now);
          check_field("leds_active_now", want_w.leds_active_now, out_word.leds_active_now);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        advance_display(in_word, want_w);
        if (want_w.refresh_request) wakes++;
        if (want_w.backlight_write && want_w.backlight_level == LEVEL_OFF) sleeps++;
        status_expected.push_back(want_w);
      end
    end
    fail_count     <= fails;
    status_backlog <= status_expected.size();
    status_checked <= checked;
    wake_count     <= wakes;
    sleep_count    <= sleeps;
  end

endmodule

// ===== tb/tb_display_sleep_controller.sv =====
`timescale 1ns / 100ps

module tb_display_sleep_controller;
  import dsc_pkg::*;

  localparam int TICKS_PER_SECOND = 1000;
  localparam int COUNTER_BITS     = 26;

  // command and field codes the package leaves unnamed
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [1:0] HOST_SPARE  = 2'd3;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [5:0]  BUSY_NONE = 6'b000000;
  localparam logic [5:0]  BUSY_ALL  = 6'b111111;
  localparam logic [15:0] SEC_MAX   = 16'hFFFF;

  localparam int RANDOM_WORDS   = 720;
  localparam int SEGMENTS       = 6;
  localparam int SETTLE_CYCLES  = 8;     // result path is two registers deep
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready = 1'b1;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int status_backlog;
  int status_checked;
  int wake_count;
  int sleep_count;

  // 1-in-N chance of an idle burst on either side, 0 turns idling off
  int idle_odds = 4;
  int out_hold  = 0;
  int words_sent = 0;
  int cfg_writes = 0;

  display_sleep_controller #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .COUNTER_BITS     (COUNTER_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dsc_result_checker #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .COUNTER_BITS     (COUNTER_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .status_backlog (status_backlog),
    .status_checked (status_checked),
    .wake_count     (wake_count),
    .sleep_count    (sleep_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure: random stall bursts
  always @(posedge clk) begin
    if (out_hold > 0) out_hold--;
    else if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) out_hold = $urandom_range(1, 13);
    out_ready <= (out_hold == 0);
  end

  // watchdog: any handshake restarts the count
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0d ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("display_sleep_controller verification failed");
    $finish;
  end

  // offer one word, optionally after an idle burst; returns on the accepting edge
  // with valid still high so back-to-back words never toggle it
  task automatic send_word(input in_word_t w);
    int gap;
    if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    // everything changes on the rising edge, so the falling edge shows the next sample
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic send_fields(input logic [2:0] cmd, input logic [1:0] host, input logic leds_on,
                             input logic [5:0] busy, input logic not_ready,
                             input logic disconnected);
    in_word_t w;
    w.command    = cmd;
    w.host_state = host;
    w.leds_on    = leds_on;
    {w.busy_printing, w.busy_homing, w.busy_probing, w.busy_leveling,
     w.busy_heating_nozzle, w.busy_heating_bed} = busy;
    w.host_not_ready    = not_ready;
    w.host_disconnected = disconnected;
    send_word(w);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_writes++;
  endtask

  // every word yields a result, so an empty backlog means the block is idle
  task automatic wait_drained();
    @(posedge clk);
    while (status_backlog != 0) @(posedge clk);
  endtask

  // stop sending, let all results come back, then rewrite every register
  task automatic reconfigure(input logic [1:0] mode, input logic enable,
                             input logic [15:0] idle_s, input logic [15:0] sleep_s,
                             input logic [15:0] delay_s);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(REG_SLEEP_MODE, 16'(mode));
    write_reg(REG_AUTO_ENABLE, 16'(enable));
    write_reg(REG_IDLE_TIMEOUT, idle_s);
    write_reg(REG_SLEEP_TIMEOUT, sleep_s);
    write_reg(REG_HOST_DELAY, delay_s);
    cfg_valid <= 1'b0;
  endtask

  // timeouts: mostly zero or one second so state changes happen, sometimes anything
  function automatic logic [15:0] pick_seconds();
    int r;
    r = $urandom_range(0, 7);
    if (r < 4) return 16'd0;
    if (r < 6) return 16'd1;
    if (r == 6) return SEC_MAX;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [2:0] pick_event();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4)  return CMD_ACTIVITY;
    if (r < 7)  return CMD_STATUS;
    if (r < 12) return CMD_HOST_STATE;
    if (r < 17) return CMD_LED_STATUS;
    if (r < 19) return CMD_HOST_TIMER;
    return $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
  endfunction

  // random content; busy flags kept rare so the sleep modes get a say
  function automatic in_word_t noisy_word(input logic [2:0] cmd);
    in_word_t   w;
    logic [5:0] busy;
    for (int i = 0; i < 6; i++) busy[i] = ($urandom_range(0, 15) == 0);
    w.command    = cmd;
    w.host_state = 2'($urandom_range(0, 3));
    w.leds_on    = 1'($urandom_range(0, 1));
    {w.busy_printing, w.busy_homing, w.busy_probing, w.busy_leveling,
     w.busy_heating_nozzle, w.busy_heating_bed} = busy;
    w.host_not_ready    = ($urandom_range(0, 5) == 0);
    w.host_disconnected = ($urandom_range(0, 5) == 0);
    return w;
  endfunction

  initial begin
    int seg;
    int sent;
    int burst;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: host sync with a 30 s delay
    send_fields(CMD_SPARE_A, HOST_READY, 1'b1, BUSY_NONE, 1'b0, 1'b0);
    send_fields(CMD_SPARE_B, HOST_PRINTING, 1'b0, BUSY_ALL, 1'b1, 1'b1);
    // odd host code reads as ready, same as tracked, so nothing moves
    send_fields(CMD_HOST_STATE, HOST_SPARE, 1'b0, BUSY_NONE, 1'b0, 1'b0);

    // led sync
    reconfigure(MODE_LED_SYNC, 1'b1, 16'd0, 16'd0, 16'd0);
    send_fields(CMD_LED_STATUS, HOST_READY, 1'b0, 6'b000001, 1'b0, 1'b0);  // busy blocks sleep
    send_fields(CMD_LED_STATUS, HOST_READY, 1'b1, BUSY_NONE, 1'b0, 1'b0);
    send_fields(CMD_LED_STATUS, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);  // leds off, sleep
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);        // already asleep
    send_fields(CMD_ACTIVITY, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);    // wake + refresh

    // timeout mode with zero timeouts: each tick walks one state further
    reconfigure(MODE_TIMEOUT, 1'b1, 16'd0, 16'd0, 16'd0);
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);
    send_fields(CMD_STATUS, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);      // wake from sleep
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);
    send_fields(CMD_STATUS, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);      // idle back to active
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_ALL, 1'b0, 1'b0);         // busy holds active
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);

    // auto sleep off: a tick wakes the sleeping display
    reconfigure(MODE_TIMEOUT, 1'b0, 16'd0, 16'd0, 16'd0);
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);

    // spare mode value with the longest timeouts: ticks never sleep
    reconfigure(MODE_SPARE, 1'b1, SEC_MAX, SEC_MAX, SEC_MAX);
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);

    // host sync with no delay
    reconfigure(MODE_HOST_SYNC, 1'b1, 16'd0, 16'd0, 16'd0);
    send_fields(CMD_HOST_STATE, HOST_IDLE, 1'b0, BUSY_NONE, 1'b0, 1'b0);
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b1, 1'b0);        // not ready blocks
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b1);        // link down blocks
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);        // sleep
    send_fields(CMD_HOST_TIMER, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);  // wake
    send_fields(CMD_TICK, HOST_READY, 1'b0, BUSY_NONE, 1'b0, 1'b0);
    send_fields(CMD_HOST_STATE, HOST_PRINTING, 1'b0, BUSY_NONE, 1'b0, 1'b0);  // leaves idle

    // random segments, each under fresh settings; the last one runs without idling
    for (seg = 0; seg < SEGMENTS; seg++) begin
      reconfigure(2'($urandom_range(0, 3)), ($urandom_range(0, 5) != 0), pick_seconds(),
                  pick_seconds(), pick_seconds());
      idle_odds = (seg == SEGMENTS - 1) ? 0 : $urandom_range(3, 12);
      sent = 0;
      while (sent < RANDOM_WORDS / SEGMENTS) begin
        if ($urandom_range(0, 2) != 0) begin
          // runs of ticks let the counters and modes act
          burst = $urandom_range(1, 8);
          repeat (burst) send_word(noisy_word(CMD_TICK));
          sent += burst;
        end else begin
          send_word(noisy_word(pick_event()));
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (status_backlog != 0)
      $display("%0d ns: %0d expected results never arrived", $time, status_backlog);
    $display("run: %0d words in, %0d results compared, %0d register writes",
             words_sent, status_checked, cfg_writes);
    $display("run: display put to sleep %0d times and woken %0d times", sleep_count, wake_count);
    if (fail_count == 0 && status_backlog == 0) begin
      $display("display_sleep_controller verification clean");
    end else begin
      $display("display_sleep_controller verification failed");
    end
    $finish;
  end

endmodule
